### design/sjk_pkg.sv
// shared types, constants and lead-byte test function for the sjis hiragana-to-katakana stream unit
package sjk_pkg;

    localparam int SJK_QDEPTH = 4;

    localparam logic [7:0] SJK_LEAD_LO1  = 8'h81;
    localparam logic [7:0] SJK_LEAD_HI1  = 8'h9F;
    localparam logic [7:0] SJK_LEAD_LO2  = 8'hE0;
    localparam logic [7:0] SJK_HIRA_LEAD = 8'h82;
    localparam logic [7:0] SJK_KATA_LEAD = 8'h83;
    localparam logic [7:0] SJK_HIRA_MIN  = 8'h9F;
    localparam logic [7:0] SJK_HIRA_SPLIT = 8'hDE;
    localparam logic [7:0] SJK_OFS_LOW   = 8'h5F;
    localparam logic [7:0] SJK_OFS_HIGH  = 8'h5E;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } sjk_item_t;

    typedef struct packed {
        logic [1:0] count;
        sjk_item_t  item0;
        sjk_item_t  item1;
        logic       hold;
        logic [7:0] held_byte;
    } sjk_conv_t;

    function automatic logic sjk_is_lead(input logic [7:0] b);
        logic r;
        r = (b inside {[SJK_LEAD_LO1:SJK_LEAD_HI1]}) || (b >= SJK_LEAD_LO2);
        return r;
    endfunction

endpackage

### design/sjk_conv.sv
// combinational byte classifier and row 4 to row 5 re-encoder
module sjk_conv
    import sjk_pkg::*;
(
    input  logic       lead_held,
    input  logic [7:0] held_lead_byte,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output sjk_conv_t  res
);

    logic       is_hira;
    logic [7:0] kata_trail;

    assign is_hira = (held_lead_byte == SJK_HIRA_LEAD) && (in_byte >= SJK_HIRA_MIN);

    // cells 1..63 land at 0x40.., cells 64..97 skip 0x7f and land at 0x80..
    assign kata_trail = (in_byte < SJK_HIRA_SPLIT) ? (in_byte - SJK_OFS_LOW)
                                                   : (in_byte - SJK_OFS_HIGH);

    always_comb begin
        res = '0;
        if (lead_held) begin
            res.count                = 2'd2;
            res.item0.out_byte       = is_hira ? SJK_KATA_LEAD : held_lead_byte;
            res.item1.out_byte       = is_hira ? kata_trail : in_byte;
            res.item1.run_end        = 1'b1;
            res.item1.string_end     = in_last;
        end else if (sjk_is_lead(in_byte) && !in_last) begin
            res.hold      = 1'b1;
            res.held_byte = in_byte;
        end else begin
            res.count            = 2'd1;
            res.item0.out_byte   = in_byte;
            res.item0.run_end    = 1'b1;
            res.item0.string_end = in_last;
        end
    end

endmodule

### design/sjk_outq.sv
// small result queue taking up to two items per cycle and giving one per cycle while out_ready is high
module sjk_outq
    import sjk_pkg::*;
#(
    parameter int DEPTH = SJK_QDEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [1:0] push_cnt,
    input  sjk_item_t push0,
    input  sjk_item_t push1,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output sjk_item_t out_item
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    sjk_item_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr1, wr2, rd1;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign wr1 = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign wr2 = (wr1 == LAST_IDX) ? '0 : wr1 + 1'b1;
    assign rd1 = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
        rd_ptr_next = pop ? rd1 : rd_ptr_reg;
        case (push_cnt)
            2'd1:    wr_ptr_next = wr1;
            2'd2:    wr_ptr_next = wr2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr1] <= push1;
        end
    end

    a_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt == 2'd2) |-> (count_reg <= CW'(DEPTH - 2)))
        else $error("pair pushed without two free entries");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_cnt == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count wrong after pop");

endmodule

### design/sjis_hiragana_to_katakana_stream_unit.sv
// top level of the sjis hiragana-to-katakana stream unit
//
// passes a shift_jis byte stream through, one byte per item, and re-encodes
// every hiragana character (lead 0x82, trail 0x9f..0xff) as the matching
// katakana (lead 0x83). bytes 0x81..0x9f and 0xe0..0xff are lead bytes: a lead
// is held and produces nothing, the next byte (any value) completes the pair
// and both bytes go out together. a lead byte that arrives with s_tlast set
// and no lead pending goes out alone and unchanged. the input channel takes
// one item every cycle while the result queue has room; a pair leaves as
// two items one after the other while m_tready stays high, balanced by the
// silent lead item, so the sustained rate is one byte per cycle each way
// when neither side stalls. items pass the input register, then the result
// queue (QDEPTH items); the input stage waits while under two entries are free.
// m_tuser carries run_end, set on the last result caused by one input item;
// m_tlast carries string_end, set on the final byte of a string.
module sjis_hiragana_to_katakana_stream_unit
    import sjk_pkg::*;
#(
    parameter int QDEPTH = SJK_QDEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] run_end
    output logic       m_tlast    // string_end
);

    // input register stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // pending lead byte
    logic       lead_held_reg, lead_held_next;
    logic [7:0] held_lead_reg, held_lead_next;

    logic       load, fire, room;
    logic [1:0] push_cnt;
    sjk_conv_t  res;
    sjk_item_t  out_item;

    assign load     = s_tvalid && s_tready;
    assign fire     = in_valid_reg && room;
    // stage frees up when its item moves into the queue this cycle
    assign s_tready = !in_valid_reg || room;

    sjk_conv u_conv (
        .lead_held      (lead_held_reg),
        .held_lead_byte (held_lead_reg),
        .in_byte        (in_byte_reg),
        .in_last        (in_last_reg),
        .res            (res)
    );

    assign push_cnt = fire ? res.count : 2'd0;

    sjk_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res.item0),
        .push1     (res.item1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.out_byte;
    assign m_tuser = out_item.run_end;
    assign m_tlast = out_item.string_end;

    always_comb begin
        in_valid_next  = in_valid_reg;
        lead_held_next = lead_held_reg;
        held_lead_next = held_lead_reg;
        if (fire) begin
            in_valid_next  = 1'b0;
            lead_held_next = res.hold;
            held_lead_next = res.held_byte;
        end
        if (load) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            lead_held_reg <= 1'b0;
            held_lead_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            lead_held_reg <= lead_held_next;
            held_lead_reg <= held_lead_next;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    a_end_clears_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last_reg) |=> !lead_held_reg)
        else $error("lead still pending after end of string");

    a_pair_clears_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && lead_held_reg) |=> !lead_held_reg)
        else $error("lead still pending after completed pair");

    a_lead_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !lead_held_reg && !in_last_reg && sjk_is_lead(in_byte_reg))
        |=> (lead_held_reg && held_lead_reg == $past(in_byte_reg)))
        else $error("lead byte not held");

endmodule
